// ===== rtl/wps_pkg.sv =====
`timescale 1ns / 1ps

package wps_pkg;

  // result kinds as seen on the result port
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FINAL  = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NOT_WAVE  = 3'd0,
    ERR_FORMAT    = 3'd1,
    ERR_CHANNELS  = 3'd2,
    ERR_BIT_DEPTH = 3'd3,
    ERR_NO_DATA   = 3'd4
  } err_t;

  // one result request, front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample_value;
    err_t               error_code;
    logic [15:0]        audio_format;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_size;
    logic [31:0]        sample_count;
    logic [31:0]        frame_count;
  } item_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [31:0] DATA_MARK = 32'h6461_7461;  // "data"

  localparam logic [15:0] PCM_FORMAT = 16'd1;

endpackage

// ===== rtl/wps_div.sv =====
`timescale 1ns / 1ps

// 32 / 16 restoring divider, one quotient bit per cycle
module wps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  import wps_pkg::*;

  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic        ge;

  assign shifted = {rem, quotient[31]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 5'd31;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[15:0] : shifted[15:0];
      quotient <= {quotient[30:0], ge};
      cnt      <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/wps_fifo.sv =====
`timescale 1ns / 1ps

// short request queue between front and back
module wps_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  wps_pkg::item_t wr_item,
  input  logic           rd,
  output wps_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  import wps_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = count == (QPTR_W + 1)'(QDEPTH);
  assign empty   = count == '0;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/wps_front.sv =====
`timescale 1ns / 1ps

// byte parser: checks the header, finds the data chunk, turns data bytes into requests
module wps_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  output logic           emit,
  output wps_pkg::item_t item
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SEARCH,
    PH_SIZE,
    PH_DATA,
    PH_IDLE
  } phase_t;

  localparam logic [7:0] SIG [16] = '{
    8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6D, 8'h74, 8'h20
  };

  phase_t      phase, phase_next;
  logic [5:0]  pos, pos_next;
  logic [31:0] window, window_next;
  logic [31:0] acc, acc_next;
  logic [31:0] remaining, remaining_next;
  logic [8:0]  held, held_next;
  logic [7:0]  fmt_byte [16];

  logic        cap_en;
  logic [5:0]  cap_off;
  logic        last;

  logic [15:0] f_format, f_channels, f_align, f_bits;
  logic [31:0] f_rate, f_byte_rate;

  assign f_format    = {fmt_byte[1], fmt_byte[0]};
  assign f_channels  = {fmt_byte[3], fmt_byte[2]};
  assign f_rate      = {fmt_byte[7], fmt_byte[6], fmt_byte[5], fmt_byte[4]};
  assign f_byte_rate = {fmt_byte[11], fmt_byte[10], fmt_byte[9], fmt_byte[8]};
  assign f_align     = {fmt_byte[13], fmt_byte[12]};
  assign f_bits      = {fmt_byte[15], fmt_byte[14]};

  assign cap_off = pos - 6'd20;
  assign last    = remaining == 32'd1;

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    window_next    = window;
    acc_next       = acc;
    remaining_next = remaining;
    held_next      = held;
    emit           = 1'b0;
    item           = '0;
    cap_en         = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos < 6'd16 && (pos < 6'd4 || pos >= 6'd8) && data_byte != SIG[pos[3:0]]) begin
            emit            = 1'b1;
            item.kind       = KIND_ERROR;
            item.error_code = ERR_NOT_WAVE;
            phase_next      = PH_IDLE;
          end else begin
            cap_en = pos >= 6'd20 && pos < 6'd36;
            if (pos >= 6'd35) begin
              if (f_format != PCM_FORMAT) begin
                emit            = 1'b1;
                item.kind       = KIND_ERROR;
                item.error_code = ERR_FORMAT;
                phase_next      = PH_IDLE;
              end else if (f_channels != 16'd1 && f_channels != 16'd2) begin
                emit            = 1'b1;
                item.kind       = KIND_ERROR;
                item.error_code = ERR_CHANNELS;
                phase_next      = PH_IDLE;
              end else begin
                phase_next  = PH_SEARCH;
                window_next = '0;
              end
            end else begin
              pos_next = pos + 6'd1;
            end
          end
        end
        PH_SEARCH: begin
          window_next = {window[23:0], data_byte};
          if (window_next == DATA_MARK) begin
            phase_next = PH_SIZE;
            pos_next   = '0;
          end
        end
        PH_SIZE: begin
          // little-endian size: shift bytes in from the top
          acc_next = {data_byte, acc[31:8]};
          pos_next = {4'd0, pos[1:0]} + 6'd1;
          if (pos[1:0] == 2'd3) begin
            if (f_bits != 16'd8 && f_bits != 16'd16) begin
              emit            = 1'b1;
              item.kind       = KIND_ERROR;
              item.error_code = ERR_BIT_DEPTH;
              phase_next      = PH_IDLE;
            end else begin
              emit                 = 1'b1;
              item.kind            = KIND_HEADER;
              item.audio_format    = f_format;
              item.channel_count   = f_channels;
              item.sample_rate     = f_rate;
              item.byte_rate       = f_byte_rate;
              item.block_align     = f_align;
              item.bits_per_sample = f_bits;
              item.data_size       = acc_next;
              item.sample_count    = (f_bits == 16'd16) ? {1'b0, acc_next[31:1]} : acc_next;
              remaining_next       = acc_next;
              held_next            = '0;
              phase_next           = (acc_next != '0) ? PH_DATA : PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          if (remaining == '0) begin
            phase_next = PH_IDLE;
          end else begin
            remaining_next = remaining - 32'd1;
            if (f_bits == 16'd8) begin
              emit              = 1'b1;
              item.kind         = last ? KIND_FINAL : KIND_SAMPLE;
              item.sample_value = {~data_byte[7], data_byte[6:0], 8'h00};
            end else if (held[8]) begin
              emit              = 1'b1;
              item.kind         = last ? KIND_FINAL : KIND_SAMPLE;
              item.sample_value = {data_byte, held[7:0]};
              held_next         = '0;
            end else if (last) begin
              // odd size: lone low byte
              emit              = 1'b1;
              item.kind         = KIND_FINAL;
              item.sample_value = {8'h00, data_byte};
            end else begin
              held_next = {1'b1, data_byte};
            end
            if (last) begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_IDLE: begin
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (end_of_file) begin
        if (!emit && (phase_next == PH_HEADER || phase_next == PH_SEARCH ||
                      phase_next == PH_SIZE)) begin
          emit            = 1'b1;
          item            = '0;
          item.kind       = KIND_ERROR;
          item.error_code = ERR_NO_DATA;
        end
        phase_next  = PH_HEADER;
        pos_next    = '0;
        window_next = '0;
        acc_next    = '0;
        held_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      fmt_byte[cap_off[3:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      window    <= '0;
      acc       <= '0;
      remaining <= '0;
      held      <= '0;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      window    <= window_next;
      acc       <= acc_next;
      remaining <= remaining_next;
      held      <= held_next;
    end
  end

endmodule

// ===== rtl/wps_back.sv =====
`timescale 1ns / 1ps

// back end: drains the queue, fills in frame count, owns the output register
module wps_back (
  input  logic           clk,
  input  logic           rst,
  input  wps_pkg::item_t head,
  input  logic           q_empty,
  output logic           q_rd,
  input  logic           pop,
  output logic           out_valid,
  output wps_pkg::item_t out_item
);
  import wps_pkg::*;

  typedef enum logic {
    B_PASS,
    B_DIV
  } bstate_t;

  bstate_t     state;
  item_t       pend;
  item_t       load_item;
  logic        slot_free;
  logic        needs_div;
  logic        div_busy;
  logic        load_pass;
  logic        load_div;
  logic [31:0] quotient;

  assign slot_free = !out_valid || pop;
  assign needs_div = head.kind == KIND_HEADER && head.block_align != '0;
  assign q_rd      = state == B_PASS && !q_empty && (needs_div || slot_free);
  assign load_pass = q_rd && !needs_div;
  assign load_div  = state == B_DIV && !div_busy && slot_free;

  wps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (q_rd && needs_div),
    .dividend (head.data_size),
    .divisor  (head.block_align),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // header out of the divider picks up its frame count
  always_comb begin
    load_item = head;
    if (load_div) begin
      load_item             = pend;
      load_item.frame_count = quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_PASS;
      out_valid <= 1'b0;
    end else begin
      if (load_pass || load_div) begin
        out_item  <= load_item;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_PASS: begin
          if (q_rd && needs_div) begin
            pend  <= head;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (load_div) begin
            state <= B_PASS;
          end
        end
        default: begin
          state <= B_PASS;
        end
      endcase
    end
  end

endmodule

// ===== rtl/wav_pcm_stream_parser.sv =====
// WAV/RIFF PCM stream parser. Bytes of a WAV file are pushed in one per cycle unless full; the
// parser checks the RIFF/WAVE/fmt signature, captures the fmt fields, finds the first
// "data" chunk and reports one header request (or an error), then one Q1.15 sample per
// 8-bit byte or 16-bit little-endian pair, the last one marked final. After an error
// the rest of the file is swallowed; end_of_file always returns the parser to the start.
// Throughput: one byte per cycle while the queue is not full. Requests go through a two-entry
// queue into the back end; a header whose block align is nonzero waits in the serial
// frame-count divider there, later requests queued behind it, while the front keeps taking
// bytes until the queue fills. Others go from the queue head to the output register once free.
`timescale 1ns / 1ps

module wav_pcm_stream_parser (
  input  logic               clk,
  input  logic               rst,
  // byte input, queue style
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  // results, queue style
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         result_kind,
  output logic signed [15:0] sample_value,
  output logic [2:0]         error_code,
  output logic [15:0]        audio_format,
  output logic [15:0]        channel_count,
  output logic [31:0]        sample_rate,
  output logic [31:0]        byte_rate,
  output logic [15:0]        block_align,
  output logic [15:0]        bits_per_sample,
  output logic [31:0]        data_size,
  output logic [31:0]        sample_count,
  output logic [31:0]        frame_count
);
  import wps_pkg::*;

  logic  accept;
  logic  f_emit;
  item_t f_item;
  logic  q_full, q_empty, q_rd;
  item_t q_head;
  logic  out_valid;
  item_t out_item;

  // front stalls on a full queue, whether or not this byte makes a request
  assign full   = q_full;
  assign accept = push && !q_full;

  wps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .emit        (f_emit),
    .item        (f_item)
  );

  wps_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_emit),
    .wr_item (f_item),
    .rd      (q_rd),
    .rd_item (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  wps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign empty           = !out_valid;
  assign result_kind     = out_item.kind;
  assign sample_value    = out_item.sample_value;
  assign error_code      = out_item.error_code;
  assign audio_format    = out_item.audio_format;
  assign channel_count   = out_item.channel_count;
  assign sample_rate     = out_item.sample_rate;
  assign byte_rate       = out_item.byte_rate;
  assign block_align     = out_item.block_align;
  assign bits_per_sample = out_item.bits_per_sample;
  assign data_size       = out_item.data_size;
  assign sample_count    = out_item.sample_count;
  assign frame_count     = out_item.frame_count;

endmodule

// ===== rtl/wps_checker.sv =====
`timescale 1ns / 1ps

module wps_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         result_kind,
  input logic signed [15:0] sample_value,
  input logic [2:0]         error_code,
  input logic [15:0]        audio_format,
  input logic [15:0]        channel_count,
  input logic [15:0]        bits_per_sample,
  input logic [31:0]        data_size,
  input logic [31:0]        frame_count
);
  import wps_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result_kind) && $stable(sample_value))
    else $error("waiting result changed");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && result_kind == KIND_ERROR |-> sample_value == 16'sd0 && data_size == '0)
    else $error("error result carries payload");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && (result_kind == KIND_SAMPLE || result_kind == KIND_FINAL)
    |-> error_code == ERR_NOT_WAVE && frame_count == '0 && audio_format == '0)
    else $error("sample result carries header fields");

  a_header_valid: assert property (@(posedge clk) disable iff (rst)
    !empty && result_kind == KIND_HEADER |-> audio_format == PCM_FORMAT
    && (channel_count == 16'd1 || channel_count == 16'd2)
    && (bits_per_sample == 16'd8 || bits_per_sample == 16'd16))
    else $error("header with unsupported format passed the checks");

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (.*);

// ===== verif/wav_pcm_stream_parser_test.sv =====
`timescale 1ns / 1ps

module wav_pcm_stream_parser_test;
  import wps_pkg::*;

  // Run bounds. The slowest run sends at least PHASE_BYTES byte requests per phase, each
  // behind a random idle gap, plus the serial frame divider once per header.
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 175;
  localparam int DRAIN_CYCLES = 100;
  localparam int DIR_ROWS     = 21;

  // "RIFF" ???? "WAVE" "fmt ", byte 0 in the top lane; bytes 4..7 are don't-care
  localparam logic [127:0] SIG_BYTES = 128'h52494646_00000000_57415645_666D7420;

  typedef enum logic [2:0] {
    SCAN_SIG, HUNT_MARK, READ_LEN, PCM_BODY, SKIP_REST
  } wav_phase_t;

  // how a directed row is checked: by the parser mirror, typed as silent, typed error
  typedef enum logic [1:0] {ROW_PARSED, ROW_QUIET, ROW_FAULT} row_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    row_mode_t  mode;
    err_t       code;
  } dir_row_t;

  // kinds of random file; the first files of the run walk them all in order
  typedef enum int {
    SC_GOOD, SC_BAD_SIG, SC_BAD_FORMAT, SC_BAD_CHANNELS, SC_BAD_DEPTH,
    SC_EMPTY_DATA, SC_CUT_HEADER, SC_CUT_SEARCH, SC_CUT_SIZE, SC_CUT_DATA,
    SC_HUGE_SIZE, SC_NOISE, SC_COUNT
  } file_shape_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [7:0]         data_byte;
  logic               end_of_file;
  logic               empty;
  logic               pop;
  logic [1:0]         result_kind;
  logic signed [15:0] sample_value;
  logic [2:0]         error_code;
  logic [15:0]        audio_format;
  logic [15:0]        channel_count;
  logic [31:0]        sample_rate;
  logic [31:0]        byte_rate;
  logic [15:0]        block_align;
  logic [15:0]        bits_per_sample;
  logic [31:0]        data_size;
  logic [31:0]        sample_count;
  logic [31:0]        frame_count;

  wav_pcm_stream_parser u_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .end_of_file     (end_of_file),
    .empty           (empty),
    .pop             (pop),
    .result_kind     (result_kind),
    .sample_value    (sample_value),
    .error_code      (error_code),
    .audio_format    (audio_format),
    .channel_count   (channel_count),
    .sample_rate     (sample_rate),
    .byte_rate       (byte_rate),
    .block_align     (block_align),
    .bits_per_sample (bits_per_sample),
    .data_size       (data_size),
    .sample_count    (sample_count),
    .frame_count     (frame_count)
  );

  // Parser mirror state, same widths as the block's own
  wav_phase_t  wav_phase;
  logic [5:0]  wav_pos;
  logic [31:0] wav_window;
  logic [31:0] wav_len_acc;
  logic [63:0] wav_fmt [2];
  logic [31:0] wav_size;
  logic [31:0] wav_left;
  logic [8:0]  wav_half;

  item_t       parsed_results [$];   // result requests still owed by the block
  logic [7:0]  file_bytes [$];       // file being sent
  dir_row_t    dir_rows [DIR_ROWS];

  // set by the sender alongside each byte request, read by the monitor
  row_mode_t   row_mode;
  err_t        row_code;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          err_count;
  int          result_idx;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", result_idx, name, got, want));
  endtask

  function automatic item_t fault_item(input err_t code);
    item_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  task automatic clear_wav_state();
    wav_phase   = SCAN_SIG;
    wav_pos     = '0;
    wav_window  = '0;
    wav_len_acc = '0;
    wav_fmt[0]  = '0;
    wav_fmt[1]  = '0;
    wav_size    = '0;
    wav_left    = '0;
    wav_half    = '0;
  endtask

  // One byte through the parser mirror; at most one result request comes out.
  task automatic parse_wav_byte(input logic [7:0] b, input logic eof,
                                output bit has, output item_t r);
    logic [5:0]  p;
    logic [5:0]  o;
    logic [15:0] fmt;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [15:0] align;
    bit          last;
    has = 1'b0;
    r = '0;
    case (wav_phase)
      SCAN_SIG: begin
        p = wav_pos;
        // signature bytes; 4..7 (RIFF size) are not checked
        if (p < 16 && (p < 4 || p >= 8) && b != SIG_BYTES[8*(15-p) +: 8]) begin
          has = 1'b1;
          r = fault_item(ERR_NOT_WAVE);
          wav_phase = SKIP_REST;
        end else begin
          if (p >= 20 && p < 36) begin
            o = p - 6'd20;
            wav_fmt[o[3]] = wav_fmt[o[3]] | (64'(b) << (8 * o[2:0]));
          end
          if (p >= 35) begin
            fmt = wav_fmt[0][15:0];
            ch  = wav_fmt[0][31:16];
            // a bad format tag wins over a bad channel count
            if (fmt != PCM_FORMAT) begin
              has = 1'b1;
              r = fault_item(ERR_FORMAT);
              wav_phase = SKIP_REST;
            end else if (ch != 16'd1 && ch != 16'd2) begin
              has = 1'b1;
              r = fault_item(ERR_CHANNELS);
              wav_phase = SKIP_REST;
            end else begin
              wav_phase = HUNT_MARK;
              wav_window = '0;
            end
          end else begin
            wav_pos = p + 6'd1;
          end
        end
      end
      HUNT_MARK: begin
        wav_window = {wav_window[23:0], b};
        if (wav_window == DATA_MARK) begin
          wav_phase = READ_LEN;
          wav_pos = '0;
          wav_len_acc = '0;
        end
      end
      READ_LEN: begin
        p = wav_pos & 6'd3;
        wav_len_acc = wav_len_acc | (32'(b) << (8 * p[1:0]));
        wav_pos = p + 6'd1;
        if (p[1:0] == 2'd3) begin
          wav_size = wav_len_acc;
          bits  = wav_fmt[1][63:48];
          align = wav_fmt[1][47:32];
          has = 1'b1;
          if (bits != 16'd8 && bits != 16'd16) begin
            // bad depth replaces the header request
            r = fault_item(ERR_BIT_DEPTH);
            wav_phase = SKIP_REST;
          end else begin
            r.kind            = KIND_HEADER;
            r.audio_format    = wav_fmt[0][15:0];
            r.channel_count   = wav_fmt[0][31:16];
            r.sample_rate     = wav_fmt[0][63:32];
            r.byte_rate       = wav_fmt[1][31:0];
            r.block_align     = align;
            r.bits_per_sample = bits;
            r.data_size       = wav_size;
            r.sample_count    = (bits == 16'd16) ? (wav_size >> 1) : wav_size;
            r.frame_count     = (align != 16'd0) ? (wav_size / {16'd0, align}) : 32'd0;
            wav_left = wav_size;
            wav_half = '0;
            // an empty data chunk goes straight to skipping
            wav_phase = (wav_size != 32'd0) ? PCM_BODY : SKIP_REST;
          end
        end
      end
      PCM_BODY: begin
        if (wav_left == 32'd0) begin
          wav_phase = SKIP_REST;
        end else begin
          wav_left = wav_left - 32'd1;
          last = (wav_left == 32'd0);
          bits = wav_fmt[1][63:48];
          if (bits == 16'd8) begin
            has = 1'b1;
            r.sample_value = {b ^ 8'h80, 8'h00};
          end else if (wav_half[8]) begin
            has = 1'b1;
            r.sample_value = {b, wav_half[7:0]};
            wav_half = '0;
          end else if (last) begin
            // odd size at 16 bits: lone byte, high half zero
            has = 1'b1;
            r.sample_value = {8'h00, b};
          end else begin
            wav_half = {1'b1, b};
          end
          if (has) begin
            if (last) r.kind = KIND_FINAL;
            else r.kind = KIND_SAMPLE;
          end
          if (last) wav_phase = SKIP_REST;
        end
      end
      default: ;
    endcase
    // end of file: no-data error if nothing else was said before the data,
    // and the parser starts over either way
    if (eof) begin
      if (!has && (wav_phase == SCAN_SIG || wav_phase == HUNT_MARK ||
                   wav_phase == READ_LEN)) begin
        has = 1'b1;
        r = fault_item(ERR_NO_DATA);
      end
      clear_wav_state();
    end
  endtask

  // Monitor: result requests checked first, then the accepted byte is parsed.
  always @(posedge clk) begin
    item_t due;
    item_t nxt;
    bit    has;
    if (!rst) begin
      if (pop && !empty) begin
        if (parsed_results.size() == 0) begin
          report_mismatch($sformatf("result request kind %0d with none outstanding",
                                    result_kind));
        end else begin
          due = parsed_results.pop_front();
          check_field("result_kind",     32'(result_kind),     32'(due.kind));
          check_field("sample_value",    32'(sample_value),    32'(due.sample_value));
          check_field("error_code",      32'(error_code),      32'(due.error_code));
          check_field("audio_format",    32'(audio_format),    32'(due.audio_format));
          check_field("channel_count",   32'(channel_count),   32'(due.channel_count));
          check_field("sample_rate",     sample_rate,          due.sample_rate);
          check_field("byte_rate",       byte_rate,            due.byte_rate);
          check_field("block_align",     32'(block_align),     32'(due.block_align));
          check_field("bits_per_sample", 32'(bits_per_sample), 32'(due.bits_per_sample));
          check_field("data_size",       data_size,            due.data_size);
          check_field("sample_count",    sample_count,         due.sample_count);
          check_field("frame_count",     frame_count,          due.frame_count);
        end
        result_idx++;
      end
      if (push && !full) begin
        parse_wav_byte(data_byte, end_of_file, has, nxt);
        case (row_mode)
          ROW_PARSED: if (has) parsed_results.push_back(nxt);
          ROW_FAULT:  parsed_results.push_back(fault_item(row_code));
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL wav_pcm_stream_parser");
      $finish;
    end
  end

  // receiver: pop drops out at random, per phase
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One byte request. Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eof,
                           input row_mode_t mode, input err_t code);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    row_mode = mode;
    row_code = code;
    push <= 1'b1;
    data_byte <= b;
    end_of_file <= eof;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  function automatic logic [31:0] field32_pick();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // sample bytes lean on the values that land on the Q1.15 extremes
  function automatic logic [7:0] data_fill_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] bad_channels();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'd3;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(3, 65535));
    endcase
  endfunction

  task automatic put_le(input logic [31:0] v, input int n);
    int k;
    for (k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
  endtask

  // Builds one file. Header is 36 bytes, then junk, "data", size, samples, tail; noise is random bytes.
  task automatic build_file(input file_shape_t shape);
    logic [15:0] fmt;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [31:0] size;
    int          junk;
    int          n_data;
    int          cut;
    int          idx;
    file_bytes.delete();
    fmt   = PCM_FORMAT;
    ch    = 16'($urandom_range(1, 2));
    bits  = $urandom_range(1) ? 16'd16 : 16'd8;
    rate  = field32_pick();
    brate = field32_pick();
    case ($urandom_range(3))
      0: align = 16'd0;
      1: align = 16'hFFFF;
      default: align = 16'($urandom_range(1, 8));
    endcase
    size = 32'($urandom_range(1, 14));
    junk = $urandom_range(0, 6);
    cut  = 0;
    case (shape)
      SC_BAD_FORMAT: begin
        case ($urandom_range(2))
          0: fmt = 16'd0;
          1: fmt = 16'hFFFF;
          default: do fmt = 16'($urandom); while (fmt == PCM_FORMAT);
        endcase
        // channels bad too now and then; format must still be the one reported
        if ($urandom_range(1)) ch = bad_channels();
      end
      SC_BAD_CHANNELS: ch = bad_channels();
      SC_BAD_DEPTH: begin
        case ($urandom_range(3))
          0: bits = 16'd0;
          1: bits = 16'hFFFF;
          2: bits = 16'd24;
          default: do bits = 16'($urandom); while (bits == 16'd8 || bits == 16'd16);
        endcase
      end
      SC_EMPTY_DATA: size = 32'd0;
      SC_CUT_DATA:   size = 32'($urandom_range(2, 14));
      SC_HUGE_SIZE:  size = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
      default: ;
    endcase
    n_data = (shape == SC_HUGE_SIZE) ? $urandom_range(0, 8) : int'(size);

    if (shape == SC_NOISE) begin
      repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
    end else begin
      for (idx = 0; idx < 16; idx++)
        file_bytes.push_back((idx >= 4 && idx < 8) ? 8'($urandom) : SIG_BYTES[8*(15-idx) +: 8]);
      put_le($urandom, 4);
      put_le(32'(fmt), 2);
      put_le(32'(ch), 2);
      put_le(rate, 4);
      put_le(brate, 4);
      put_le(32'(align), 2);
      put_le(32'(bits), 2);
      // junk before the marker, salted with pieces of "data" to tease the search
      repeat (junk) begin
        case ($urandom_range(5))
          0: file_bytes.push_back(8'h64);
          1: file_bytes.push_back(8'h61);
          2: file_bytes.push_back(8'h74);
          default: file_bytes.push_back(8'($urandom));
        endcase
      end
      put_le(32'h6174_6164, 4);   // "data" in file order
      put_le(size, 4);
      repeat (n_data) file_bytes.push_back(data_fill_byte());
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));

      if (shape == SC_BAD_SIG) begin
        idx = $urandom_range(0, 11);
        if (idx >= 4) idx += 4;
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      case (shape)
        SC_CUT_HEADER: cut = $urandom_range(1, 35);
        SC_CUT_SEARCH: cut = $urandom_range(37, 40 + junk);
        SC_CUT_SIZE:   cut = $urandom_range(41 + junk, 43 + junk);
        SC_CUT_DATA:   cut = 44 + junk + $urandom_range(1, int'(size) - 1);
        default: ;
      endcase
      while (cut > 0 && file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    int          i;
    int          ph;
    int          files_done;
    int          phase_bytes;
    file_shape_t shape;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    data_byte = 8'h00;
    end_of_file = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    row_mode = ROW_PARSED;
    row_code = ERR_NOT_WAVE;
    err_count = 0;
    result_idx = 0;
    cycle_count = 0;
    clear_wav_state();

    // Directed rows: short files and signature faults whose outcome is plain
    dir_rows = '{
      '{8'h00, 1'b0, ROW_FAULT, ERR_NOT_WAVE},  // zero at byte 0 right after reset
      '{8'hFF, 1'b0, ROW_QUIET, ERR_NOT_WAVE},  // swallowed after the error
      '{8'h00, 1'b1, ROW_QUIET, ERR_NOT_WAVE},  // eof while skipping says nothing
      '{8'hFF, 1'b1, ROW_FAULT, ERR_NOT_WAVE},  // bad first byte that is also eof
      '{8'h52, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h49, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h46, 1'b1, ROW_FAULT, ERR_NO_DATA},   // file ends inside the header
      '{8'h52, 1'b1, ROW_FAULT, ERR_NO_DATA},   // one-byte file
      '{8'h52, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h49, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h46, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h46, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'hFF, 1'b0, ROW_QUIET, ERR_NOT_WAVE},  // RIFF size bytes, unchecked
      '{8'h00, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h80, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h7F, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h57, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h41, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'h56, 1'b0, ROW_QUIET, ERR_NOT_WAVE},
      '{8'hC5, 1'b0, ROW_FAULT, ERR_NOT_WAVE},  // WAVE broken in its last byte
      '{8'h20, 1'b1, ROW_QUIET, ERR_NOT_WAVE}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].b, dir_rows[i].eof, dir_rows[i].mode, dir_rows[i].code);

    // Random files in four pacing phases: free running, slow sender,
    // stalling receiver, both a little. Once every shape has had its turn, half the files are well formed.
    files_done = 0;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if (files_done < SC_COUNT) shape = file_shape_t'(files_done);
        else if ($urandom_range(99) < 50) shape = SC_GOOD;
        else shape = file_shape_t'($urandom_range(1, SC_COUNT - 1));
        build_file(shape);
        for (i = 0; i < file_bytes.size(); i++)
          send_byte(file_bytes[i], i == file_bytes.size() - 1, ROW_PARSED, ERR_NOT_WAVE);
        phase_bytes += file_bytes.size();
        files_done++;
      end
    end

    push <= 1'b0;
    recv_stall_pct = 0;
    while (parsed_results.size() != 0) @(posedge clk);
    // drain wait, so a stray late result request still gets caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("PASS wav_pcm_stream_parser");
    else $display("FAIL wav_pcm_stream_parser");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wps_pkg.sv
rtl/wps_div.sv
rtl/wps_fifo.sv
rtl/wps_front.sv
rtl/wps_back.sv
rtl/wav_pcm_stream_parser.sv
rtl/wps_checker.sv
verif/wav_pcm_stream_parser_test.sv
